// ----- rtl/core/cfc_pkg.sv -----
package cfc_pkg;

	localparam int MAX_CHUNKS_DEF = 16;
	localparam int LIST_LIMIT     = 16;
	localparam int ID_W           = 8;
	localparam int OWN_W          = 8;
	localparam int SIZE_W         = 14;
	localparam int BYTES_W        = 10;
	localparam logic [SIZE_W-1:0] SIZE_SAT = 14'd16383;

	localparam logic [1:0] CMD_APPEND  = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_LIST    = 2'd2;
	localparam logic [1:0] CMD_NOP     = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [OWN_W-1:0]  owner;
		logic [SIZE_W-1:0] size;
		logic              is_free;
	} entry_t;

	function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
			input logic [SIZE_W-1:0] b);
		logic [SIZE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, SIZE_SAT}) ? SIZE_SAT : s[SIZE_W-1:0];
	endfunction

	// a ranks ahead of b in the free list
	function automatic logic ranks_before(input entry_t a, input entry_t b);
		if (a.size == b.size) return a.id < b.id;
		return a.size > b.size;
	endfunction

endpackage

// ----- rtl/core/cfc_table.sv -----
module cfc_table import cfc_pkg::*; #(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
	localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [MAX_CHUNKS];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/chunk_free_coalescer.sv -----
// Append: result strobed in the cycle after the accepting edge; busy stays low.
// Release: per table entry, S_REL_R reads it and S_REL_W merges it into the pending
// entry or writes the pending entry; S_REL_F writes the last one, S_DONE answers;
// owner 0 or an empty table goes straight to S_DONE. List: one selection pass over
// the table for each listed chunk, up to LIST_LIMIT; an empty table or a table with
// no free chunk answers ST_EMPTY. Results are strobed for one cycle; the receiver
// cannot stall. arst_n clears count, id counter and control; table is not cleared.
module chunk_free_coalescer import cfc_pkg::*; #(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
	localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
	localparam int CW = $clog2(MAX_CHUNKS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [OWN_W-1:0]   owner,
	input  logic [BYTES_W-1:0] chunk_bytes,
	output logic               strobe,
	output logic [1:0]         status,
	output logic [ID_W-1:0]    chunk_id,
	output logic [SIZE_W-1:0]  chunk_size,
	output logic               last
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_REL_R = 8'b0000_0010,
		S_REL_W = 8'b0000_0100,
		S_REL_F = 8'b0000_1000,
		S_LST_R = 8'b0001_0000,
		S_LST_W = 8'b0010_0000,
		S_LST_E = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q, rd_q, wr_q, nlisted_q, nfree_q;
	logic [ID_W:0] next_id_q;
	logic [OWN_W-1:0] own_q;
	// release: held entry not yet written (pending)
	entry_t pend_q;
	logic pend_v_q;
	// release: pending chunk was freed last and may still take one free successor
	logic absorb_q;
	// list: last emitted key, current best
	entry_t prev_q, best_q;
	logic prev_v_q, best_v_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	entry_t wdata, rdata;

	cfc_table #(.MAX_CHUNKS(MAX_CHUNKS)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign busy = (state_q != S_IDLE);

	// read address: current scan position
	assign raddr = rd_q[AW-1:0];

	entry_t rel_e, rel_merged;
	logic rel_hit;
	always_comb begin
		rel_e = rdata;
		rel_hit = !rdata.is_free && rdata.owner == own_q;
		if (rel_hit) begin
			rel_e.is_free = 1'b1;
			rel_e.owner = '0;
		end
		rel_merged = pend_q;
		rel_merged.size = sat_add(pend_q.size, rel_e.size);
	end

	// Merge rule: a freed chunk joins a free pending chunk, which keeps its id; an
	// already free chunk joins only a pending chunk whose latest part was freed in
	// this pass and that has not yet taken a successor.
	logic merge;
	assign merge = pend_v_q && pend_q.is_free && rel_e.is_free && (rel_hit || absorb_q);

	always_comb begin
		we = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = pend_q;
		unique case (state_q)
			S_IDLE: begin
				we = start && command == CMD_APPEND && count_q < CW'(MAX_CHUNKS)
					&& !next_id_q[ID_W];
				waddr = count_q[AW-1:0];
				wdata.id = next_id_q[ID_W-1:0];
				wdata.owner = owner;
				wdata.size = SIZE_W'(chunk_bytes);
				wdata.is_free = (owner == '0);
			end
			S_REL_W: begin
				// flush pending when the new entry does not merge into it
				we = pend_v_q && !merge;
			end
			S_REL_F: begin
				we = pend_v_q;
			end
			default: ;
		endcase
	end

	logic lst_cand;
	assign lst_cand = rdata.is_free && (!prev_v_q || ranks_before(prev_q, rdata))
		&& (!best_v_q || ranks_before(rdata, best_q));

	// free chunks in the table, complete at the end of the first pass
	logic [CW-1:0] lst_total;
	logic lst_final;
	assign lst_total = prev_v_q ? nfree_q : nfree_q + CW'(rdata.is_free);
	assign lst_final = (nlisted_q + 1'b1 == lst_total)
		|| (nlisted_q + 1'b1 == CW'(LIST_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			next_id_q <= '0;
			strobe <= 1'b0;
			rd_q <= '0;
			wr_q <= '0;
			pend_v_q <= 1'b0;
			absorb_q <= 1'b0;
			prev_v_q <= 1'b0;
			best_v_q <= 1'b0;
			nlisted_q <= '0;
			nfree_q <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					own_q <= owner;
					rd_q <= '0;
					wr_q <= '0;
					pend_v_q <= 1'b0;
					absorb_q <= 1'b0;
					prev_v_q <= 1'b0;
					best_v_q <= 1'b0;
					nlisted_q <= '0;
					nfree_q <= '0;
					unique case (command)
						CMD_APPEND: begin
							strobe <= 1'b1;
							last <= 1'b1;
							if (we) begin
								status <= ST_OK;
								chunk_id <= next_id_q[ID_W-1:0];
								chunk_size <= SIZE_W'(chunk_bytes);
								count_q <= count_q + 1'b1;
								next_id_q <= next_id_q + 1'b1;
							end else begin
								status <= ST_FULL;
								chunk_id <= '0;
								chunk_size <= '0;
							end
						end
						CMD_RELEASE: state_q <= (owner == '0 || count_q == '0)
							? S_DONE : S_REL_R;
						CMD_LIST: state_q <= (count_q == '0) ? S_LST_E : S_LST_R;
						default: ;
					endcase
				end
				S_REL_R: state_q <= S_REL_W;
				S_REL_W: begin
					if (merge) begin
						pend_q <= rel_merged;
					end else begin
						if (pend_v_q) wr_q <= wr_q + 1'b1;
						pend_q <= rel_e;
						pend_v_q <= 1'b1;
					end
					absorb_q <= rel_hit;
					rd_q <= rd_q + 1'b1;
					state_q <= (rd_q + 1'b1 == count_q) ? S_REL_F : S_REL_R;
				end
				S_REL_F: begin
					count_q <= wr_q + 1'b1;
					state_q <= S_DONE;
				end
				S_LST_R: state_q <= S_LST_W;
				S_LST_W: begin
					if (lst_cand) best_q <= rdata;
					if (!prev_v_q && rdata.is_free) nfree_q <= nfree_q + 1'b1;
					if (rd_q + 1'b1 == count_q) begin
						rd_q <= '0;
						best_v_q <= 1'b0;
						if (lst_cand || best_v_q) begin
							strobe <= 1'b1;
							status <= ST_OK;
							chunk_id <= lst_cand ? rdata.id : best_q.id;
							chunk_size <= lst_cand ? rdata.size : best_q.size;
							prev_q <= lst_cand ? rdata : best_q;
							prev_v_q <= 1'b1;
							nlisted_q <= nlisted_q + 1'b1;
							last <= lst_final;
							state_q <= lst_final ? S_IDLE : S_LST_R;
						end else begin
							state_q <= (nlisted_q == '0) ? S_LST_E : S_IDLE;
						end
					end else begin
						if (lst_cand) best_v_q <= 1'b1;
						rd_q <= rd_q + 1'b1;
						state_q <= S_LST_R;
					end
				end
				S_LST_E: begin
					strobe <= 1'b1;
					status <= ST_EMPTY;
					chunk_id <= '0;
					chunk_size <= '0;
					last <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DONE: begin
					strobe <= 1'b1;
					status <= ST_OK;
					chunk_id <= '0;
					chunk_size <= '0;
					last <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/cfc_checker.sv -----
module cfc_checker import cfc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [1:0] status,
	input logic       last
);

	a_idle_after_reset: assert property (@(posedge clk) $rose(arst_n) |-> !busy)
		else $error("busy out of reset");

	a_busy_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without a transaction");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == ST_EMPTY |-> last)
		else $error("empty list not final");

	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == ST_FULL |-> last)
		else $error("full status not final");

	a_known_status: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> status == ST_OK || status == ST_FULL || status == ST_EMPTY)
		else $error("bad status");

endmodule

bind chunk_free_coalescer cfc_checker u_cfc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.strobe(strobe), .status(status), .last(last)
);
